@@ rtl/core/cso_pkg.sv @@
`default_nettype none
package cso_pkg;

   localparam int RING_DEPTH = 10;
   localparam int ADC_BITS   = 12;

   localparam int IDX_W    = $clog2(RING_DEPTH);
   localparam int SAMPLE_W = ADC_BITS + 1;
   // nine samples of SAMPLE_W bits plus headroom
   localparam int SUM_W    = SAMPLE_W + $clog2(RING_DEPTH);
   localparam int OUT_W    = 16;
   localparam int DIFF_W   = ((SUM_W > OUT_W) ? SUM_W : OUT_W) + 1;
   localparam int COEF_W   = 17;
   localparam int PROD_W   = DIFF_W + COEF_W;
   localparam int ACC_W    = 32;
   localparam int ACC_SHIFT   = 15;
   localparam int SCALE_SHIFT = 14;

   localparam int WINDOW_W = 16;
   localparam int GAIN_W   = 15;
   localparam int SCALE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3000;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 15'd1024;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd16384;

   typedef struct packed {
      logic step;
      logic mul_gain;
      logic acc;
      logic mul_scale;
      logic out_load;
   } cso_cmd_type;

   function automatic logic signed [OUT_W-1:0] sat16(input logic signed [31:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/cso_csr.sv @@
`default_nettype none
module cso_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [cso_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cso_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic      [cso_pkg::WINDOW_W-1:0]     window_ms,
   output logic      [cso_pkg::GAIN_W-1:0]       gain,
   output logic      [cso_pkg::SCALE_W-1:0]      scale
);
   import cso_pkg::*;

   logic [WINDOW_W-1:0] window_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [SCALE_W-1:0]  scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         gain_ff   <= GAIN_RESET;
         scale_ff  <= SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW: window_ff <= csr_data[WINDOW_W-1:0];
            CSR_GAIN:   gain_ff   <= csr_data[GAIN_W-1:0];
            CSR_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   assign window_ms = window_ff;
   assign gain      = gain_ff;
   assign scale     = scale_ff;

endmodule
`default_nettype wire

@@ rtl/core/cso_ctrl.sv @@
`default_nettype none
module cso_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output cso_pkg::cso_cmd_type      cmd
);
   import cso_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_GAIN,
      S_ACC,
      S_MUL_SCALE,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load;

   assign accept = (state_ff == S_IDLE) && req_tvalid;
   // result register frees up in the same cycle it is transferred
   assign load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_tvalid) state_in = S_MUL_GAIN;
         S_MUL_GAIN:  state_in = S_ACC;
         S_ACC:       state_in = S_MUL_SCALE;
         S_MUL_SCALE: state_in = S_OUT;
         S_OUT:       if (load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready    = (state_ff == S_IDLE);
   assign rsp_tvalid    = rsp_valid_ff;
   assign cmd.step      = accept;
   assign cmd.mul_gain  = (state_ff == S_MUL_GAIN);
   assign cmd.acc       = (state_ff == S_ACC);
   assign cmd.mul_scale = (state_ff == S_MUL_SCALE);
   assign cmd.out_load  = load;

endmodule
`default_nettype wire

@@ rtl/core/cso_dp.sv @@
`default_nettype none
module cso_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cso_pkg::cso_cmd_type                cmd,
   input  wire logic [11:0]                         adc_sample,
   input  wire logic                                motor_running,
   input  wire logic [31:0]                         time_ms,
   input  wire logic [cso_pkg::WINDOW_W-1:0]        window_ms,
   input  wire logic [cso_pkg::GAIN_W-1:0]          gain,
   input  wire logic [cso_pkg::SCALE_W-1:0]         scale,
   output logic signed [cso_pkg::OUT_W-1:0]         filtered_value,
   output logic signed [cso_pkg::OUT_W-1:0]         motor_current
);
   import cso_pkg::*;

   logic        [ADC_BITS-1:0]  offset_ff, offset_in;
   logic signed [SAMPLE_W-1:0]  ring_ff [RING_DEPTH];
   logic        [IDX_W-1:0]     idx_ff, idx_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic        [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [OUT_W-1:0]     fo_ff, fo_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [OUT_W-1:0]     fv_ff, cur_ff;

   logic        [ADC_BITS-1:0]  sample;
   logic        [ADC_BITS:0]    half_sum;
   logic                        learn;
   logic signed [SAMPLE_W-1:0]  corrected;
   logic signed [DIFF_W-1:0]    mul_a;
   logic signed [COEF_W-1:0]    mul_b;
   logic signed [OUT_W-1:0]     cur_in;

   // ---- ring step, done in the transfer cycle
   assign sample   = adc_sample[ADC_BITS-1:0];
   assign learn    = !motor_running && (time_ms < {16'd0, window_ms});
   assign half_sum = {1'b0, offset_ff} + {1'b0, sample};
   assign offset_in = learn ? half_sum[ADC_BITS:1] : offset_ff;
   assign corrected = $signed({1'b0, sample}) - $signed({1'b0, offset_in});
   assign idx_in = (idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   // slot at the advanced index drops out of the window
   assign sum_in = sum_ff + SUM_W'(corrected) - SUM_W'(ring_ff[idx_in]);

   // ---- shared multiplier
   always_comb begin
      if (cmd.mul_scale) begin
         mul_a = DIFF_W'(fo_ff);
         mul_b = $signed({1'b0, scale});
      end else begin
         mul_a = DIFF_W'(sum_ff) - DIFF_W'(fo_ff);
         mul_b = $signed({2'b00, gain});
      end
   end
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // ---- accumulate and saturate
   assign acc_in = acc_ff + prod_ff[ACC_W-1:0];
   assign fo_in  = sat16(32'($signed(acc_in[ACC_W-1:ACC_SHIFT])));
   assign cur_in = sat16(32'($signed(prod_ff[PROD_W-1:SCALE_SHIFT])));

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         idx_ff    <= '0;
         sum_ff    <= '0;
         acc_ff    <= '0;
         fo_ff     <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (cmd.step) begin
            offset_ff       <= offset_in;
            ring_ff[idx_ff] <= corrected;
            idx_ff          <= idx_in;
            sum_ff          <= sum_in;
         end
         if (cmd.acc) begin
            acc_ff <= acc_in;
            fo_ff  <= fo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_gain || cmd.mul_scale) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         fv_ff  <= fo_ff;
         cur_ff <= cur_in;
      end
   end

   assign filtered_value = fv_ff;
   assign motor_current  = cur_ff;

endmodule
`default_nettype wire

@@ rtl/core/current_sense_offset_filter.sv @@
`default_nettype none
// the result is registered after the states MUL_GAIN, ACC, MUL_SCALE and OUT, and OUT waits
// while a held result is not taken; a new item is accepted only in IDLE, so the pace is set
// by the single shared multiplier, used once for the filter gain and once for the scale
// reset: synchronous, active high; clears offset, ring, window sum and filter state
// and restores the calibration window, gain and scale registers to their defaults
module current_sense_offset_filter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,   // adc_sample[11:0], time_ms[43:12], zero pad
   input  wire logic         req_tuser,   // motor_running
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [31:0]  rsp_tdata,   // filtered_value[15:0], motor_current[31:16]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [cso_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cso_pkg::CSR_DATA_W-1:0] csr_data
);
   import cso_pkg::*;

   cso_cmd_type         cmd;
   logic [WINDOW_W-1:0] window_ms;
   logic [GAIN_W-1:0]   gain;
   logic [SCALE_W-1:0]  scale;
   logic signed [OUT_W-1:0] filtered_value;
   logic signed [OUT_W-1:0] motor_current;

   assign csr_ready = 1'b1;

   cso_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .window_ms (window_ms),
      .gain      (gain),
      .scale     (scale)
   );

   cso_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cso_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .adc_sample     (req_tdata[11:0]),
      .motor_running  (req_tuser),
      .time_ms        (req_tdata[43:12]),
      .window_ms      (window_ms),
      .gain           (gain),
      .scale          (scale),
      .filtered_value (filtered_value),
      .motor_current  (motor_current)
   );

   assign rsp_tdata = {motor_current, filtered_value};

endmodule
`default_nettype wire

@@ sim/tb_current_sense_offset_filter.sv @@
`timescale 1ns / 100ps

typedef struct packed {
   logic signed [15:0] current;
   logic signed [15:0] filtered;
} cso_result_type;

class offset_filter_scoreboard;
   logic [15:0] window_ms;
   logic [14:0] gain;
   logic [15:0] scale;

   logic [11:0] offset;
   int ring [cso_pkg::RING_DEPTH];
   int slot;
   int window_sum;
   logic [31:0] acc;
   int fout;

   cso_result_type pending_results[$];
   int errors;
   int samples_seen;
   int results_checked;

   function new();
      window_ms = cso_pkg::WINDOW_RESET;
      gain      = cso_pkg::GAIN_RESET;
      scale     = cso_pkg::SCALE_RESET;
      offset    = '0;
      foreach (ring[i]) ring[i] = 0;
      slot       = 0;
      window_sum = 0;
      acc        = '0;
      fout       = 0;
      errors          = 0;
      samples_seen    = 0;
      results_checked = 0;
   endfunction

   static function int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function void write_reg(logic [cso_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
         cso_pkg::CSR_WINDOW: window_ms = val;
         cso_pkg::CSR_GAIN:   gain = val[14:0];
         cso_pkg::CSR_SCALE:  scale = val;
         default: ;
      endcase
   endfunction

   function void take_sample(logic [11:0] s, logic run, logic [31:0] t);
      int corr;
      int acc_s;
      longint diff;
      longint prod;
      cso_result_type r;
      if (!run && t < {16'd0, window_ms})
         offset = 12'((13'(offset) + 13'(s)) >> 1);
      corr = int'(s) - int'(offset);
      ring[slot] = corr;
      window_sum += corr;
      slot = (slot + 1) % cso_pkg::RING_DEPTH;
      window_sum -= ring[slot];
      diff = longint'(window_sum) - longint'(fout);
      // accumulator wraps modulo 2^32
      acc = acc + 32'(diff * longint'(gain));
      acc_s = $signed(acc);
      fout = clamp16(longint'(acc_s) >>> 15);
      prod = longint'(fout) * longint'(scale);
      r.filtered = 16'(fout);
      r.current  = 16'(clamp16(prod >>> 14));
      pending_results.push_back(r);
      samples_seen++;
   endfunction

   function void report_miss(string what, int expv, int actv);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, expv, actv);
   endfunction

   function void compare_result(logic [31:0] data);
      cso_result_type r;
      if (pending_results.size() == 0) begin
         report_miss("unexpected result (filtered_value)", 0, $signed(data[15:0]));
         return;
      end
      r = pending_results.pop_front();
      results_checked++;
      if (data[15:0] !== r.filtered)
         report_miss("filtered_value", r.filtered, $signed(data[15:0]));
      if (data[31:16] !== r.current)
         report_miss("motor_current", r.current, $signed(data[31:16]));
   endfunction
endclass

module tb_current_sense_offset_filter;
   import cso_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 104;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_reqs = 0;
   int holds_done = 0;
   int hold_left = 0;
   int csr_writes = 0;

   offset_filter_scoreboard sb = new();

   current_sense_offset_filter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // receiver: random stalls, or one long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != hold_reqs) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.take_sample(req_tdata[11:0], req_tuser, req_tdata[43:12]);
         if (rsp_tvalid && rsp_tready)
            sb.compare_result(rsp_tdata);
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            csr_writes++;
         end
      end
   end

   task automatic send_sample(input logic [11:0] s, input logic run, input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, t, s};
      req_tuser  <= run;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_filter_regs(input logic [15:0] w, input logic [15:0] g,
                                  input logic [15:0] sc);
      write_csr(CSR_WINDOW, w);
      write_csr(CSR_GAIN, g);
      write_csr(CSR_SCALE, sc);
   endtask

   initial begin
      logic [11:0] s;
      logic run;
      logic [31:0] t;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // learning at and around the calibration window, full-range time
      send_sample(12'd0, 1'b0, 32'd0);
      send_sample(12'hFFF, 1'b0, 32'd0);
      send_sample(12'hFFF, 1'b0, 32'd2999);
      send_sample(12'hFFF, 1'b0, 32'd3000);
      send_sample(12'd0, 1'b0, 32'hFFFF_FFFF);
      send_sample(12'hAAA, 1'b1, 32'd0);
      send_sample(12'h555, 1'b0, 32'h5555_5555);
      send_sample(12'hFFF, 1'b0, 32'hAAAA_AAAA);
      wait_results_drained();

      // max gain and scale push the accumulator into wrap and both outputs into saturation;
      // gain bit 15 must be dropped and the unmapped index ignored
      set_filter_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_csr(CSR_UNMAPPED, 16'h1234);
      repeat (6) send_sample(12'hFFF, 1'b1, 32'd0);
      repeat (5) send_sample(12'd0, 1'b1, 32'd0);
      wait_results_drained();

      set_filter_regs(16'd0, 16'd0, 16'd0);
      send_sample(12'hFFF, 1'b0, 32'd0);
      send_sample(12'd0, 1'b1, 32'd1);
      send_sample(12'h800, 1'b0, 32'd0);
      wait_results_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_filter_regs(WINDOW_RESET, 16'(GAIN_RESET), SCALE_RESET);
            1: set_filter_regs(16'hFFFF, 16'h7FFF, 16'hFFFF);
            2: set_filter_regs(16'd0, 16'd1, 16'd1);
            default: set_filter_regs(16'($urandom_range(65535)),
                                     16'($urandom_range(32767) >> $urandom_range(5)),
                                     16'($urandom_range(65535)));
         endcase
         if (p == 3) write_csr(CSR_UNMAPPED, 16'($urandom));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == 20) hold_reqs++;
            if (p == 5 && i == PHASE_ITEMS / 2) wait_results_drained();
            if ($urandom_range(4) == 0)
               s = $urandom_range(1) ? 12'hFFF : 12'd0;
            else
               s = 12'($urandom_range(4095));
            run = ($urandom_range(2) == 0);
            case ($urandom_range(3))
               0: t = $urandom_range(32'(sb.window_ms));
               1: t = $urandom;
               2: t = 32'(sb.window_ms) + $urandom_range(2) - 1;
               default: t = $urandom_range(200);
            endcase
            send_sample(s, run, t);
         end
         wait_results_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report_miss("results never delivered", 0, sb.pending_results.size());
      $display("%0d samples sent through %0d register writes, %0d results compared",
               sb.samples_seen, csr_writes, sb.results_checked);
      $display("idle and stall mixes, one long output hold-off and one full drain included");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
